@@ hdl/wavp_pkg.sv @@
// Shared types, constants and lookup functions for the WAV header parser.
package wavp_pkg;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       is_final;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [15:0] channels;
		logic [31:0] sample_rate;
		logic [31:0] byte_rate;
		logic [15:0] block_align;
		logic [15:0] bits_per_sample;
		logic [31:0] data_offset;
		logic [31:0] data_size;
	} out_item_t;

	typedef struct packed {
		logic     valid;
		in_item_t item;
	} stage_t;

	typedef struct packed {
		logic      valid;
		out_item_t result;
	} push_t;

	localparam logic [3:0] ST_OK       = 4'd0;
	localparam logic [3:0] ST_SHORT    = 4'd1;
	localparam logic [3:0] ST_BAD_HDR  = 4'd2;
	localparam logic [3:0] ST_OVERRUN  = 4'd3;
	localparam logic [3:0] ST_NO_FMT   = 4'd4;
	localparam logic [3:0] ST_NO_DATA  = 4'd5;
	localparam logic [3:0] ST_NOT_PCM  = 4'd6;
	localparam logic [3:0] ST_CHANNELS = 4'd7;
	localparam logic [3:0] ST_BITS     = 4'd8;
	localparam logic [3:0] ST_EMPTY    = 4'd9;

	localparam logic [3:0]  HEADER_LAST = 4'd11;
	localparam logic [31:0] FMT_MIN     = 32'd16;
	localparam logic [31:0] ID_FMT      = 32'h2074_6D66;
	localparam logic [31:0] ID_DATA     = 32'h6174_6164;
	localparam logic [15:0] PCM_CODE    = 16'd1;
	localparam logic [15:0] CH_MONO     = 16'd1;
	localparam logic [15:0] CH_STEREO   = 16'd2;
	localparam logic [15:0] BITS_8      = 16'd8;
	localparam logic [15:0] BITS_16     = 16'd16;

	function automatic logic [7:0] magic_byte(input logic [3:0] idx);
		logic [7:0] r;
		r = 8'h00;
		unique case (idx)
			4'd0:    r = 8'h52;
			4'd1:    r = 8'h49;
			4'd2:    r = 8'h46;
			4'd3:    r = 8'h46;
			4'd8:    r = 8'h57;
			4'd9:    r = 8'h41;
			4'd10:   r = 8'h56;
			4'd11:   r = 8'h45;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic magic_checked(input logic [3:0] idx);
		logic r;
		r = 1'b0;
		unique case (idx) inside
			[4'd0:4'd3], [4'd8:4'd11]: r = 1'b1;
			default:                   r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

@@ hdl/wavp_in_reg.sv @@
// Input register stage for incoming file bytes.
module wavp_in_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid,
	output logic              ready,
	input  wavp_pkg::in_item_t item,
	input  logic              advance,
	output wavp_pkg::stage_t  stage
);

	logic               valid_s1;
	wavp_pkg::in_item_t item_s1;

	assign ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (valid && ready) begin
			item_s1 <= item;
		end
	end

	assign stage.valid = valid_s1;
	assign stage.item  = item_s1;

endmodule

@@ hdl/wavp_core.sv @@
// Chunk walker: parser state, format capture and final verdict.
module wavp_core (
	input  logic              clk,
	input  logic              arst_n,
	input  wavp_pkg::stage_t  stage,
	input  logic              slot_free,
	output logic              advance,
	output wavp_pkg::push_t   push
);

	typedef enum logic [1:0] {PH_FILE, PH_CHDR, PH_BODY, PH_PAD} phase_t;

	phase_t      phase_q, phase_d;
	logic [31:0] position_q, position_d;
	logic        header_ok_q, header_ok_d;
	logic [63:0] shift_q, shift_d;
	logic [2:0]  hcount_q, hcount_d;
	logic [31:0] remaining_q, remaining_d;
	logic        pad_q, pad_d;
	logic        in_fmt_q, in_fmt_d;
	logic [4:0]  fmt_idx_q, fmt_idx_d;
	logic [7:0]  fmt_q [16];
	logic [7:0]  fmt_d [16];
	logic        seen_fmt_q, seen_fmt_d;
	logic        seen_data_q, seen_data_d;
	logic [31:0] data_offset_q, data_offset_d;
	logic [31:0] data_size_q, data_size_d;

	logic [7:0]  b;
	logic        fin;
	logic [63:0] hdr_shift;
	logic [31:0] hdr_id;
	logic [31:0] hdr_size;
	logic        hdr_fmt;

	logic [15:0] code_d;
	logic [15:0] ch_d;
	logic [15:0] bits_d;
	logic [3:0]  status;
	logic        fail;

	assign b         = stage.item.byte_value;
	assign fin       = stage.item.is_final;
	assign advance   = stage.valid && (!fin || slot_free);
	assign hdr_shift = {b, shift_q[63:8]};
	assign hdr_id    = hdr_shift[31:0];
	assign hdr_size  = hdr_shift[63:32];
	assign hdr_fmt   = (hdr_id == wavp_pkg::ID_FMT) && (hdr_size >= wavp_pkg::FMT_MIN);

	always_comb begin
		phase_d       = phase_q;
		position_d    = position_q + 32'd1;
		header_ok_d   = header_ok_q;
		shift_d       = shift_q;
		hcount_d      = hcount_q;
		remaining_d   = remaining_q;
		pad_d         = pad_q;
		in_fmt_d      = in_fmt_q;
		fmt_idx_d     = fmt_idx_q;
		fmt_d         = fmt_q;
		seen_fmt_d    = seen_fmt_q;
		seen_data_d   = seen_data_q;
		data_offset_d = data_offset_q;
		data_size_d   = data_size_q;
		unique case (phase_q)
			PH_FILE: begin
				if (wavp_pkg::magic_checked(position_q[3:0]) &&
						b != wavp_pkg::magic_byte(position_q[3:0])) begin
					header_ok_d = 1'b0;
				end
				if (position_q[3:0] == wavp_pkg::HEADER_LAST) begin
					phase_d  = PH_CHDR;
					hcount_d = 3'd0;
				end
			end
			PH_CHDR: begin
				shift_d  = hdr_shift;
				hcount_d = hcount_q + 3'd1;
				if (hcount_q == 3'd7) begin
					in_fmt_d = hdr_fmt;
					if (hdr_fmt) begin
						seen_fmt_d = 1'b1;
					end else if (hdr_id == wavp_pkg::ID_DATA) begin
						seen_data_d   = 1'b1;
						data_offset_d = position_d;
						data_size_d   = hdr_size;
					end
					remaining_d = hdr_size;
					pad_d       = hdr_size[0];
					fmt_idx_d   = 5'd0;
					if (hdr_size != 32'd0) begin
						phase_d = PH_BODY;
					end
				end
			end
			PH_BODY: begin
				if (!fmt_idx_q[4]) begin
					if (in_fmt_q) begin
						fmt_d[fmt_idx_q[3:0]] = b;
					end
					fmt_idx_d = fmt_idx_q + 5'd1;
				end
				remaining_d = remaining_q - 32'd1;
				if (remaining_q == 32'd1) begin
					phase_d = pad_q ? PH_PAD : PH_CHDR;
				end
			end
			PH_PAD: begin
				pad_d   = 1'b0;
				phase_d = PH_CHDR;
			end
		endcase
	end

	assign code_d = {fmt_d[1], fmt_d[0]};
	assign ch_d   = {fmt_d[3], fmt_d[2]};
	assign bits_d = {fmt_d[15], fmt_d[14]};

	always_comb begin
		if (phase_d == PH_FILE) begin
			status = wavp_pkg::ST_SHORT;
		end else if (!header_ok_d) begin
			status = wavp_pkg::ST_BAD_HDR;
		end else if (phase_d == PH_BODY) begin
			status = wavp_pkg::ST_OVERRUN;
		end else if (!seen_fmt_d) begin
			status = wavp_pkg::ST_NO_FMT;
		end else if (!seen_data_d) begin
			status = wavp_pkg::ST_NO_DATA;
		end else if (code_d != wavp_pkg::PCM_CODE) begin
			status = wavp_pkg::ST_NOT_PCM;
		end else if (ch_d != wavp_pkg::CH_MONO && ch_d != wavp_pkg::CH_STEREO) begin
			status = wavp_pkg::ST_CHANNELS;
		end else if (bits_d != wavp_pkg::BITS_8 && bits_d != wavp_pkg::BITS_16) begin
			status = wavp_pkg::ST_BITS;
		end else if (data_size_d == 32'd0) begin
			status = wavp_pkg::ST_EMPTY;
		end else begin
			status = wavp_pkg::ST_OK;
		end
	end

	assign fail = (status >= wavp_pkg::ST_SHORT) && (status <= wavp_pkg::ST_NO_DATA);

	always_comb begin
		push.valid         = advance && fin;
		push.result.status = status;
		if (fail) begin
			push.result.channels        = 16'd0;
			push.result.sample_rate     = 32'd0;
			push.result.byte_rate       = 32'd0;
			push.result.block_align     = 16'd0;
			push.result.bits_per_sample = 16'd0;
			push.result.data_offset     = 32'd0;
			push.result.data_size       = 32'd0;
		end else begin
			push.result.channels        = ch_d;
			push.result.sample_rate     = {fmt_d[7], fmt_d[6], fmt_d[5], fmt_d[4]};
			push.result.byte_rate       = {fmt_d[11], fmt_d[10], fmt_d[9], fmt_d[8]};
			push.result.block_align     = {fmt_d[13], fmt_d[12]};
			push.result.bits_per_sample = bits_d;
			push.result.data_offset     = data_offset_d;
			push.result.data_size       = data_size_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_FILE;
			position_q    <= 32'd0;
			header_ok_q   <= 1'b1;
			shift_q       <= 64'd0;
			hcount_q      <= 3'd0;
			remaining_q   <= 32'd0;
			pad_q         <= 1'b0;
			in_fmt_q      <= 1'b0;
			fmt_idx_q     <= 5'd0;
			for (int i = 0; i < 16; i++) begin
				fmt_q[i] <= 8'h00;
			end
			seen_fmt_q    <= 1'b0;
			seen_data_q   <= 1'b0;
			data_offset_q <= 32'd0;
			data_size_q   <= 32'd0;
		end else if (advance) begin
			if (fin) begin
				phase_q       <= PH_FILE;
				position_q    <= 32'd0;
				header_ok_q   <= 1'b1;
				shift_q       <= 64'd0;
				hcount_q      <= 3'd0;
				remaining_q   <= 32'd0;
				pad_q         <= 1'b0;
				in_fmt_q      <= 1'b0;
				fmt_idx_q     <= 5'd0;
				for (int i = 0; i < 16; i++) begin
					fmt_q[i] <= 8'h00;
				end
				seen_fmt_q    <= 1'b0;
				seen_data_q   <= 1'b0;
				data_offset_q <= 32'd0;
				data_size_q   <= 32'd0;
			end else begin
				phase_q       <= phase_d;
				position_q    <= position_d;
				header_ok_q   <= header_ok_d;
				shift_q       <= shift_d;
				hcount_q      <= hcount_d;
				remaining_q   <= remaining_d;
				pad_q         <= pad_d;
				in_fmt_q      <= in_fmt_d;
				fmt_idx_q     <= fmt_idx_d;
				fmt_q         <= fmt_d;
				seen_fmt_q    <= seen_fmt_d;
				seen_data_q   <= seen_data_d;
				data_offset_q <= data_offset_d;
				data_size_q   <= data_size_d;
			end
		end
	end

	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |=> (phase_q == PH_FILE) && (position_q == 32'd0) && !seen_fmt_q)
		else $error("state not cleared after final byte");

	a_body_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_BODY) |-> (remaining_q != 32'd0))
		else $error("chunk body with nothing remaining");

	a_hcount_chdr: assert property (@(posedge clk) disable iff (!arst_n)
		(hcount_q != 3'd0) |-> (phase_q == PH_CHDR))
		else $error("header byte count outside chunk header");

	a_push_slot: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> slot_free && stage.valid)
		else $error("result pushed into a full slot");

endmodule

@@ hdl/wavp_out_reg.sv @@
// Result register that holds a verdict until the transfer completes.
module wavp_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  wavp_pkg::push_t     push,
	output logic                slot_free,
	output logic                valid,
	input  logic                ready,
	output wavp_pkg::out_item_t data
);

	logic                valid_q;
	wavp_pkg::out_item_t result_q;

	assign slot_free = !valid_q || ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (slot_free) begin
			valid_q <= push.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid && slot_free) begin
			result_q <= push.result;
		end
	end

	assign valid = valid_q;
	assign data  = result_q;

endmodule

@@ hdl/wav_header_chunk_parser.sv @@
// Top level of the WAV header and chunk parser.
// Feed a WAV file one byte per transfer on the byte channel, with is_final set on the last
// byte; one verdict comes out on the result channel for each file. The block takes one byte
// every cycle: each byte passes an input register and a single pass of counter and field
// logic, and the verdict is held in a result register until its transfer. All parser state
// returns to its reset value with the final byte, so the next file may start in the very
// next cycle; no clearing pass is needed. The byte channel stalls only when a final byte
// meets a verdict that is still waiting.
module wav_header_chunk_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_ready,
	input  wavp_pkg::in_item_t  byte_data,
	output logic                result_valid,
	input  logic                result_ready,
	output wavp_pkg::out_item_t result_data
);

	wavp_pkg::stage_t stage;
	wavp_pkg::push_t  push;
	logic             advance;
	logic             slot_free;

	wavp_in_reg u_in_reg (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid   (byte_valid),
		.ready   (byte_ready),
		.item    (byte_data),
		.advance (advance),
		.stage   (stage)
	);

	wavp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.stage     (stage),
		.slot_free (slot_free),
		.advance   (advance),
		.push      (push)
	);

	wavp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.slot_free (slot_free),
		.valid     (result_valid),
		.ready     (result_ready),
		.data      (result_data)
	);

endmodule

@@ dv/wav_parser_checker.sv @@
`timescale 1ns / 100ps
// Checker for the WAV header parser: tracks the byte stream, predicts each verdict, compares.
module wav_parser_checker
	import wavp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	input  logic      byte_ready,
	input  in_item_t  byte_data,
	input  logic      result_valid,
	input  logic      result_ready,
	input  out_item_t result_data,
	output int        fail_count,
	output int        pending
);

	typedef enum logic [1:0] {PH_FILE, PH_CHDR, PH_BODY, PH_PAD} parse_phase_t;

	localparam logic [31:0] SIG_RIFF = "RIFF";
	localparam logic [31:0] SIG_WAVE = "WAVE";

	out_item_t    verdict_q[$];
	int           fails = 0;
	int           waiting = 0;

	logic [31:0]  offset;
	parse_phase_t phase;
	logic         magic_ok;
	logic [63:0]  hdr_shift;
	int           hdr_count;
	logic [31:0]  body_left;
	logic         pad_due;
	logic         in_fmt;
	logic [7:0]   fmt_body [16];
	logic         have_fmt;
	logic         have_data;
	logic [31:0]  data_off;
	logic [31:0]  data_len;

	assign fail_count = fails;
	assign pending    = waiting;

	function automatic logic [7:0] sig_byte(input logic [31:0] pos);
		int p;
		p = pos;
		if (p < 4) begin
			return SIG_RIFF[31 - 8 * p -: 8];
		end
		return SIG_WAVE[31 - 8 * (p - 8) -: 8];
	endfunction

	task automatic clear_parse();
		offset    = '0;
		phase     = PH_FILE;
		magic_ok  = 1'b1;
		hdr_shift = '0;
		hdr_count = 0;
		body_left = '0;
		pad_due   = 1'b0;
		in_fmt    = 1'b0;
		have_fmt  = 1'b0;
		have_data = 1'b0;
		data_off  = '0;
		data_len  = '0;
		foreach (fmt_body[i]) fmt_body[i] = '0;
	endtask

	task automatic report(input string msg);
		$display("ERROR %0t: %s", $realtime, msg);
		fails++;
	endtask

	task automatic absorb_byte(input in_item_t it);
		logic [31:0] csize;
		logic [31:0] idx;
		logic [15:0] ch;
		logic [15:0] bits;
		out_item_t   v;
		case (phase)
			PH_FILE: begin
				if ((offset < 4 || offset >= 8) && it.byte_value != sig_byte(offset))
					magic_ok = 1'b0;
				if (offset == 11) begin
					phase     = PH_CHDR;
					hdr_count = 0;
				end
			end
			PH_CHDR: begin
				hdr_shift = {it.byte_value, hdr_shift[63:8]};
				hdr_count++;
				if (hdr_count >= 8) begin
					hdr_count = 0;
					csize     = hdr_shift[63:32];
					in_fmt    = (hdr_shift[31:0] == ID_FMT) && (csize >= FMT_MIN);
					if (in_fmt) begin
						have_fmt = 1'b1;
					end else if (hdr_shift[31:0] == ID_DATA) begin
						have_data = 1'b1;
						data_off  = offset + 32'd1;
						data_len  = csize;
					end
					body_left = csize;
					pad_due   = csize[0];
					if (csize != 0)
						phase = PH_BODY;
				end
			end
			PH_BODY: begin
				idx = hdr_shift[63:32] - body_left;
				if (in_fmt && idx < 16)
					fmt_body[idx[3:0]] = it.byte_value;
				if (body_left != 0)
					body_left--;
				if (body_left == 0) begin
					phase     = pad_due ? PH_PAD : PH_CHDR;
					hdr_count = 0;
				end
			end
			default: begin
				pad_due   = 1'b0;
				phase     = PH_CHDR;
				hdr_count = 0;
			end
		endcase
		offset++;
		if (!it.is_final)
			return;

		ch   = {fmt_body[3], fmt_body[2]};
		bits = {fmt_body[15], fmt_body[14]};
		v    = '0;
		if (phase == PH_FILE)                          v.status = ST_SHORT;
		else if (!magic_ok)                            v.status = ST_BAD_HDR;
		else if (phase == PH_BODY)                     v.status = ST_OVERRUN;
		else if (!have_fmt)                            v.status = ST_NO_FMT;
		else if (!have_data)                           v.status = ST_NO_DATA;
		else if ({fmt_body[1], fmt_body[0]} != PCM_CODE) v.status = ST_NOT_PCM;
		else if (ch != CH_MONO && ch != CH_STEREO)     v.status = ST_CHANNELS;
		else if (bits != BITS_8 && bits != BITS_16)    v.status = ST_BITS;
		else if (data_len == 0)                        v.status = ST_EMPTY;
		else                                           v.status = ST_OK;
		if (!(v.status >= ST_SHORT && v.status <= ST_NO_DATA)) begin
			v.channels        = ch;
			v.sample_rate     = {fmt_body[7], fmt_body[6], fmt_body[5], fmt_body[4]};
			v.byte_rate       = {fmt_body[11], fmt_body[10], fmt_body[9], fmt_body[8]};
			v.block_align     = {fmt_body[13], fmt_body[12]};
			v.bits_per_sample = bits;
			v.data_offset     = data_off;
			v.data_size       = data_len;
		end
		verdict_q.push_back(v);
		waiting++;
		clear_parse();
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report($sformatf("%s: got 0x%0h, want 0x%0h", name, got, want));
	endtask

	task automatic compare_result(input out_item_t got);
		out_item_t want;
		if (verdict_q.size() == 0) begin
			report($sformatf("result with status %0d and no verdict pending", got.status));
			return;
		end
		want = verdict_q.pop_front();
		waiting--;
		check_field("status", got.status, want.status);
		check_field("channels", got.channels, want.channels);
		check_field("sample_rate", got.sample_rate, want.sample_rate);
		check_field("byte_rate", got.byte_rate, want.byte_rate);
		check_field("block_align", got.block_align, want.block_align);
		check_field("bits_per_sample", got.bits_per_sample, want.bits_per_sample);
		check_field("data_offset", got.data_offset, want.data_offset);
		check_field("data_size", got.data_size, want.data_size);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parse();
			verdict_q.delete();
			waiting = 0;
		end else begin
			if (result_valid && result_ready)
				compare_result(result_data);
			if (byte_valid && byte_ready)
				absorb_byte(byte_data);
		end
	end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench top for the WAV header parser: clock, reset, file stimulus and the verdict.
module tb_top;
	import wavp_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 8;
	localparam int RANDOM_BYTES   = 1050;
	localparam int MIN_FILES      = 24;
	localparam int QUIET_FROM     = 880;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      byte_valid = 1'b0;
	logic      byte_ready;
	in_item_t  byte_data = '0;
	logic      result_valid;
	logic      result_ready = 1'b0;
	out_item_t result_data;
	int        fail_count;
	int        pending;

	bit          idle_on = 1'b1;
	int          ready_hold = 0;
	int          stall_cycles = 0;
	int          bytes_sent = 0;
	int          files_sent = 0;
	logic [7:0]  file_q[$];

	wav_header_chunk_parser dut (.*);
	wav_parser_checker u_chk (.*);

	always #1 clk = ~clk;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			ready_hold   <= 0;
		end else if (ready_hold != 0) begin
			ready_hold   <= ready_hold - 1;
			result_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			ready_hold   <= $urandom_range(0, 13);
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((byte_valid && byte_ready) || (result_valid && result_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("wav_header_chunk_parser: mismatch");
			$finish;
		end
	end

	task automatic put_byte(input logic [7:0] b, input logic fin);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_data  <= '{byte_value: b, is_final: fin};
		@(posedge clk);
		while (!byte_ready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_file();
		foreach (file_q[i]) put_byte(file_q[i], i == file_q.size() - 1);
		files_sent++;
	endtask

	// hold the byte channel until every verdict has been taken
	task automatic drain();
		byte_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
	endtask

	task automatic add_le(input logic [31:0] v, input int n);
		for (int i = 0; i < n; i++) file_q.push_back(v[8 * i +: 8]);
	endtask

	task automatic add_tag(input logic [31:0] tag);
		for (int i = 3; i >= 0; i--) file_q.push_back(tag[8 * i +: 8]);
	endtask

	task automatic add_body(input logic [31:0] size);
		for (int i = 0; i < size; i++) file_q.push_back(8'($urandom));
		if (size[0])
			file_q.push_back(8'($urandom));
	endtask

	task automatic start_file();
		file_q.delete();
		add_tag("RIFF");
		add_le($urandom, 4);
		add_tag("WAVE");
	endtask

	task automatic trim_to(input int n);
		while (file_q.size() > n) void'(file_q.pop_back());
	endtask

	task automatic add_fmt(input logic [31:0] size, input logic [15:0] code,
		input logic [15:0] ch, input logic [31:0] rate, input logic [31:0] brate,
		input logic [15:0] align, input logic [15:0] bits);
		add_tag("fmt ");
		add_le(size, 4);
		if (size < FMT_MIN) begin
			add_body(size);
		end else begin
			add_le(32'(code), 2);
			add_le(32'(ch), 2);
			add_le(rate, 4);
			add_le(brate, 4);
			add_le(32'(align), 2);
			add_le(32'(bits), 2);
			add_body(size - FMT_MIN);
		end
	endtask

	task automatic add_chunk(input logic [31:0] id, input logic [31:0] size);
		add_tag(id);
		add_le(size, 4);
		add_body(size);
	endtask

	task automatic add_good_fmt();
		add_fmt(FMT_MIN, PCM_CODE, CH_STEREO, $urandom, $urandom, 16'($urandom), BITS_16);
	endtask

	task automatic run_directed();
		start_file();
		add_fmt(FMT_MIN, PCM_CODE, CH_MONO, 32'd8000, 32'd8000, 16'd1, BITS_8);
		add_chunk("data", 4);
		send_file();

		start_file();
		add_fmt(FMT_MIN, PCM_CODE, CH_STEREO, '1, '1, '1, BITS_16);
		add_chunk("data", 3);
		send_file();

		file_q = '{8'h52};
		send_file();

		start_file();
		trim_to(11);
		send_file();

		start_file();
		send_file();

		start_file();
		file_q[9] = 8'h00;
		add_good_fmt();
		add_chunk("data", 2);
		send_file();

		// huge data body cut short
		start_file();
		add_good_fmt();
		add_tag("data");
		add_le('1, 4);
		add_le($urandom, 2);
		send_file();

		start_file();
		add_tag("fmt ");
		add_le(32'h8000_0000, 4);
		add_le($urandom, 4);
		send_file();

		start_file();
		add_good_fmt();
		send_file();

		start_file();
		add_chunk("data", 4);
		send_file();

		start_file();
		add_fmt(32'd14, PCM_CODE, CH_MONO, '0, '0, '0, BITS_8);
		add_chunk("data", 2);
		send_file();

		start_file();
		add_fmt(FMT_MIN, 16'd3, CH_MONO, $urandom, $urandom, 16'd4, BITS_16);
		add_chunk("data", 2);
		send_file();

		start_file();
		add_fmt(FMT_MIN, PCM_CODE, 16'd0, $urandom, $urandom, 16'd1, BITS_8);
		add_chunk("data", 2);
		send_file();

		start_file();
		add_fmt(FMT_MIN, PCM_CODE, 16'd3, $urandom, $urandom, 16'd1, BITS_8);
		add_chunk("data", 2);
		send_file();

		start_file();
		add_fmt(FMT_MIN, PCM_CODE, CH_MONO, $urandom, $urandom, 16'd3, 16'd24);
		add_chunk("data", 2);
		send_file();

		start_file();
		add_good_fmt();
		add_chunk("data", 0);
		send_file();

		// later fmt and data chunks win; file ends where only the pad byte is missing
		start_file();
		add_fmt(32'd19, 16'd3, 16'd5, $urandom, $urandom, 16'($urandom), 16'd24);
		add_chunk($urandom, 5);
		add_fmt(FMT_MIN, PCM_CODE, CH_MONO, '0, '0, '0, BITS_8);
		add_chunk("data", 2);
		add_chunk("data", 5);
		trim_to(file_q.size() - 1);
		send_file();

		start_file();
		add_good_fmt();
		add_chunk("data", 4);
		add_le($urandom, 3);
		send_file();
	endtask

	task automatic random_file();
		int          kind;
		int          pos;
		logic [31:0] sz;
		logic [15:0] code;
		logic [15:0] ch;
		logic [15:0] bits;
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			file_q.delete();
			repeat ($urandom_range(1, 30)) file_q.push_back(8'($urandom));
		end else if (kind < 14) begin
			start_file();
			trim_to($urandom_range(1, 11));
		end else begin
			start_file();
			if (kind < 20) begin
				pos = $urandom_range(0, 7);
				if (pos >= 4)
					pos += 4;
				file_q[pos] ^= 8'($urandom_range(1, 255));
			end
			if ($urandom_range(0, 4) == 0)
				add_chunk($urandom, $urandom_range(0, 6));
			if ($urandom_range(0, 9) != 0) begin
				case ($urandom_range(0, 9))
					0:       sz = $urandom_range(0, 15);
					1, 2:    sz = $urandom_range(17, 20);
					default: sz = FMT_MIN;
				endcase
				code = ($urandom_range(0, 6) != 0) ? PCM_CODE : 16'($urandom);
				ch   = ($urandom_range(0, 6) != 0) ? 16'($urandom_range(1, 2)) : 16'($urandom);
				bits = ($urandom_range(0, 6) != 0) ? ($urandom_range(0, 1) ? BITS_8 : BITS_16)
				                                   : 16'($urandom);
				add_fmt(sz, code, ch, $urandom, $urandom, 16'($urandom), bits);
			end
			if ($urandom_range(0, 4) == 0)
				add_chunk($urandom, $urandom_range(0, 6));
			if ($urandom_range(0, 9) != 0)
				add_chunk("data", ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 9));
			case ($urandom_range(0, 9))
				0:       trim_to(file_q.size() - $urandom_range(1, 3));
				1:       add_le($urandom, $urandom_range(1, 3));
				2:       begin
					add_le($urandom, 4);
					add_le($urandom, $urandom_range(1, 3));
				end
				default: ;
			endcase
		end
		send_file();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		drain();
		while (bytes_sent < RANDOM_BYTES || files_sent < MIN_FILES) begin
			if (bytes_sent >= QUIET_FROM)
				idle_on = 1'b0;
			else
				idle_on = ($urandom_range(0, 4) != 0);
			random_file();
			if ($urandom_range(0, 9) == 0)
				drain();
		end
		idle_on = 1'b0;
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("wav_header_chunk_parser: match");
		else
			$display("wav_header_chunk_parser: mismatch");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/wavp_pkg.sv
hdl/wavp_in_reg.sv
hdl/wavp_core.sv
hdl/wavp_out_reg.sv
hdl/wav_header_chunk_parser.sv
dv/wav_parser_checker.sv
dv/tb_top.sv
